// ===== rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
package mexp_pkg;

	localparam int DATA_W = 32;
	localparam int REG_W  = 32;
	localparam int ADDR_W = 1;

	localparam logic [ADDR_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [ADDR_W-1:0] REG_MODULUS  = 1'b1;

	// multiply unit operations
	typedef enum logic [1:0] {
		OP_RED,  // base * 1, reduces the base
		OP_MUL,  // acc * sq
		OP_SQR   // sq * sq
	} mop_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_CHKM,
		S_MUL,
		S_CHKS,
		S_SQR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		mop_t op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic e_lsb;
		logic e_more;
	} status_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// channel  dir  signals                       word
// s_axis   in   tvalid tready tdata[TW-1:0]   base in low WIDTH bits, TW = WIDTH up to whole bytes
// m_axis   out  tvalid tready tdata[TW-1:0]   power in low WIDTH bits, zero-filled above
// cfg      in   cfg_we cfg_addr cfg_wdata     0 exponent, 1 modulus
//
// Steps per word: accept the base, reduce it, then per exponent bit up to its top set bit
// a check plus a multiply when the bit is set, and a check plus a square when higher bits
// remain; finally load the output. Reduction, multiply and square all run on the single
// bit-serial modular multiplier.
// Reset: exponent 1, modulus 2, no word in flight.
// A finished word waits in the output register; the next base is taken meanwhile. A second
// finished word holds the block in its output state until the first one is taken.
module modular_exponentiation #(
	parameter int WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [((WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // base
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [((WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // power
	input  logic                            cfg_we,
	input  logic [mexp_pkg::ADDR_W-1:0]     cfg_addr,
	input  logic [mexp_pkg::REG_W-1:0]      cfg_wdata
);
	import mexp_pkg::*;

	localparam int TDATA_W = ((WIDTH + 7) / 8) * 8;

	logic [WIDTH-1:0] exp_q, mod_q, power;
	cmd_t             cmd;
	status_t          status;

	// key registers, low WIDTH bits kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= WIDTH'(1);
			mod_q <= WIDTH'(2);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_EXPONENT: exp_q <= cfg_wdata[WIDTH-1:0];
				REG_MODULUS:  mod_q <= cfg_wdata[WIDTH-1:0];
				default: ;
			endcase
		end
	end

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	mexp_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.base     (s_axis_tdata[WIDTH-1:0]),
		.exponent (exp_q),
		.modulus  (mod_q),
		.power    (power)
	);

	assign m_axis_tdata = TDATA_W'(power);

	// the multiplier is never busy while a new base can be taken
	a_idle_mul: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !status.busy)
		else $error("multiplier busy while accepting");

	// a nonzero exponent and a nonzero modulus give a reduced result
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mod_q != '0 && exp_q != '0 |-> power < mod_q)
		else $error("result not reduced");

	// exponent zero gives one
	a_exp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && exp_q == '0 |-> power == WIDTH'(1))
		else $error("exponent zero result not one");

endmodule

// ===== rtl/mexp_datapath.sv =====
`timescale 1ns / 1ps
module mexp_datapath #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mexp_pkg::cmd_t    cmd,
	output mexp_pkg::status_t status,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] exponent,
	input  logic [WIDTH-1:0] modulus,
	output logic [WIDTH-1:0] power
);
	import mexp_pkg::*;

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] acc_q, sq_q, e_q, m_q, a_q, b_q, r_q, out_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	mop_t             op_q;

	logic [WIDTH+1:0] t, m1, m2;
	logic [WIDTH-1:0] r_next;
	logic             done;

	// one bit of the multiplier per cycle, MSB first, reduced every step
	always_comb begin
		m1 = {2'b00, m_q};
		m2 = {1'b0, m_q, 1'b0};
		t  = {1'b0, r_q, 1'b0} + (a_q[WIDTH-1] ? {2'b00, b_q} : '0);
		if (m_q == '0) begin
			r_next = t[WIDTH-1:0];
		end else if (t >= m2) begin
			r_next = WIDTH'(t - m2);
		end else if (t >= m1) begin
			r_next = WIDTH'(t - m1);
		end else begin
			r_next = t[WIDTH-1:0];
		end
	end

	assign done = busy_q && (cnt_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= WIDTH'(1);
			e_q   <= exponent;
			m_q   <= modulus;
		end
		if (cmd.start) begin
			op_q <= cmd.op;
			r_q  <= '0;
			unique case (cmd.op)
				OP_RED: begin
					a_q <= base;
					b_q <= WIDTH'(1);
				end
				OP_MUL: begin
					a_q <= acc_q;
					b_q <= sq_q;
				end
				default: begin
					a_q <= sq_q;
					b_q <= sq_q;
				end
			endcase
		end else if (busy_q) begin
			r_q <= r_next;
			a_q <= {a_q[WIDTH-2:0], 1'b0};
			if (done) begin
				unique case (op_q)
					OP_RED: sq_q <= r_next;
					OP_MUL: acc_q <= r_next;
					default: begin
						sq_q <= r_next;
						e_q  <= {1'b0, e_q[WIDTH-1:1]};
					end
				endcase
			end
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	assign status.busy   = busy_q;
	assign status.done   = done;
	assign status.e_lsb  = e_q[0];
	assign status.e_more = |e_q[WIDTH-1:1];
	assign power         = out_q;

endmodule

// ===== rtl/mexp_ctrl.sv =====
`timescale 1ns / 1ps
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mexp_pkg::cmd_t    cmd,
	input  mexp_pkg::status_t status
);
	import mexp_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_RED;
			S_RED:  if (status.done) state_nxt = S_CHKM;
			S_CHKM: state_nxt = status.e_lsb ? S_MUL : S_CHKS;
			S_MUL:  if (status.done) state_nxt = S_CHKS;
			S_CHKS: state_nxt = status.e_more ? S_SQR : S_OUT;
			S_SQR:  if (status.done) state_nxt = S_CHKM;
			S_OUT:  if (!out_valid_q || out_ready) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = OP_RED;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = in_valid;
				cmd.start = in_valid;
			end
			S_CHKM: begin
				cmd.start = status.e_lsb;
				cmd.op    = OP_MUL;
			end
			S_CHKS: begin
				cmd.start = status.e_more;
				cmd.op    = OP_SQR;
			end
			S_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
